[rtl/es_pkg.sv]
// es_pkg: shared types and constants of the exponential search block.
// Holds the item structs, the queued command format and the opcodes.
// No dependencies.
package es_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned POS_W   = 10;
  // Probe and range indexes: a probe may reach twice the largest length
  localparam int unsigned IDX_W   = LEN_W + 1;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(1024);

  // Entries of the queue between front and engine (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;

  // Opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                       opcode;
    logic [ADDR_W-1:0]          address;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
  } out_item_t;

  // Classified command handed from front to engine
  typedef struct packed {
    logic                       is_search;
    logic [ADDR_W-1:0]          addr;
    logic signed [VALUE_W-1:0]  value;
    logic [LEN_W-1:0]           count;
  } cmd_t;

endpackage

[rtl/es_front.sv]
// es_front: accepts input items and classifies them into engine commands.
// Drops writes beyond the store, clamps the length for searches.
// Depends on es_pkg.
module es_front #(
  parameter int unsigned DEPTH = es_pkg::DEPTH_DEFAULT
) (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  es_pkg::in_item_t         in_data,
  input  logic [es_pkg::LEN_W-1:0] length,
  output logic                     push,
  input  logic                     push_ready,
  output es_pkg::cmd_t             push_cmd
);

  logic drop;
  logic [es_pkg::LEN_W-1:0] count;

  // Clamp the length in use to the store depth
  always_comb begin
    if (32'(length) > 32'(DEPTH)) begin
      count = es_pkg::LEN_W'(DEPTH);
    end else begin
      count = length;
    end
  end

  // Drop writes that fall outside the store
  assign drop = (in_data.opcode == es_pkg::OP_WRITE) &&
                (32'(in_data.address) >= 32'(DEPTH));

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready && !drop;

  always_comb begin
    push_cmd.is_search = (in_data.opcode == es_pkg::OP_SEARCH);
    push_cmd.addr      = in_data.address;
    push_cmd.value     = in_data.value;
    push_cmd.count     = count;
  end

endmodule

[rtl/es_queue.sv]
// es_queue: short command queue between the front and the search engine.
// Lets either side stall on its own. Depends on es_pkg.
module es_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         push_ready,
  input  es_pkg::cmd_t push_cmd,
  output logic         pop_valid,
  input  logic         pop,
  output es_pkg::cmd_t pop_cmd
);

  localparam int unsigned QW = (es_pkg::QUEUE_DEPTH > 1) ? $clog2(es_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(es_pkg::QUEUE_DEPTH + 1);

  es_pkg::cmd_t   slots [es_pkg::QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr;
  logic [QW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (32'(fill) < 32'(es_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

[rtl/es_engine.sv]
// es_engine: sorted store and the exponential search sequencer.
// One memory read per probe or binary step, result held in an output register.
// Depends on es_pkg.
module es_engine #(
  parameter int unsigned DEPTH = es_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  es_pkg::cmd_t      cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output es_pkg::out_item_t out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW = es_pkg::IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ZERO  = 3'd1;
  localparam logic [2:0] S_GROW  = 3'd2;
  localparam logic [2:0] S_SPLIT = 3'd3;
  localparam logic [2:0] S_BIN   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic signed [es_pkg::VALUE_W-1:0] mem [DEPTH];
  logic signed [es_pkg::VALUE_W-1:0] rdata;
  logic        mem_we;
  logic [31:0] wr_wide;
  logic [31:0] rd_wide;
  logic [IW-1:0] rd_idx;

  logic [2:0] state, state_next;
  logic signed [es_pkg::VALUE_W-1:0] key, key_next;
  logic [es_pkg::LEN_W-1:0] count, count_next;
  logic [IW-1:0] probe, probe_next;
  logic [IW-1:0] lo, lo_next;
  logic [IW-1:0] hi, hi_next;
  logic [IW-1:0] mid, mid_next;
  logic hit, hit_next;
  logic [es_pkg::POS_W-1:0] pos, pos_next;
  logic load_out;

  assign wr_wide = 32'(cmd.addr);
  assign rd_wide = 32'(rd_idx);

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_wide[AW-1:0]] <= cmd.value;
    end
    rdata <= mem[rd_wide[AW-1:0]];
  end

  // Sequence probes and binary steps
  always_comb begin
    logic [IW-1:0] cnt_w;
    logic [IW-1:0] dbl;
    logic [IW-1:0] lo_c;
    logic [IW-1:0] hi_c;
    logic [IW:0]   sum;
    logic          go_on;

    cnt_w      = IW'(count);
    dbl        = '0;
    lo_c       = lo;
    hi_c       = hi;
    sum        = '0;
    go_on      = 1'b0;
    state_next = state;
    key_next   = key;
    count_next = count;
    probe_next = probe;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    hit_next   = hit;
    pos_next   = pos;
    rd_idx     = '0;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    load_out   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (!cmd.is_search) begin
            mem_we = 1'b1;
          end else begin
            key_next   = cmd.value;
            count_next = cmd.count;
            hit_next   = 1'b0;
            pos_next   = '0;
            if (cmd.count == '0) begin
              state_next = S_DONE;
            end else begin
              rd_idx     = '0;
              state_next = S_ZERO;
            end
          end
        end
      end
      S_ZERO: begin
        if (rdata == key) begin
          hit_next   = 1'b1;
          pos_next   = '0;
          state_next = S_DONE;
        end else begin
          probe_next = IW'(1);
          if (IW'(1) < cnt_w) begin
            rd_idx     = IW'(1);
            state_next = S_GROW;
          end else begin
            state_next = S_SPLIT;
          end
        end
      end
      S_GROW: begin
        // Double the probe while the element stays below the key
        if (rdata < key) begin
          dbl        = probe << 1;
          probe_next = dbl;
          if (dbl < cnt_w) begin
            rd_idx = dbl;
          end else begin
            state_next = S_SPLIT;
          end
        end else begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        // Set up the closing range and read its midpoint
        lo_c = probe >> 1;
        hi_c = (probe < cnt_w - IW'(1)) ? probe : cnt_w - IW'(1);
        sum  = {1'b0, lo_c} + {1'b0, hi_c};
        lo_next    = lo_c;
        hi_next    = hi_c;
        mid_next   = sum[IW:1];
        rd_idx     = sum[IW:1];
        state_next = S_BIN;
      end
      S_BIN: begin
        if (key < rdata) begin
          go_on = (lo < mid);
          hi_c  = mid - IW'(1);
        end else if (rdata < key) begin
          go_on = (mid < hi);
          lo_c  = mid + IW'(1);
        end
        if (rdata == key) begin
          hit_next   = 1'b1;
          pos_next   = mid[es_pkg::POS_W-1:0];
          state_next = S_DONE;
        end else if (go_on) begin
          sum      = {1'b0, lo_c} + {1'b0, hi_c};
          lo_next  = lo_c;
          hi_next  = hi_c;
          mid_next = sum[IW:1];
          rd_idx   = sum[IW:1];
        end else begin
          hit_next   = 1'b0;
          pos_next   = '0;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    count <= count_next;
    probe <= probe_next;
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
    hit   <= hit_next;
    pos   <= pos_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.found    <= hit;
      out_data.position <= pos;
    end
  end

endmodule

[rtl/exponential_search.sv]
// exponential_search: sorted word store with exponential search.
// Input channel (in_valid/in_ready/in_data): an item with opcode write puts
// value into the store at address; an item with opcode search looks for value.
// Output channel (out_valid/out_ready/out_data): one item per search with the
// found flag and the zero-based position; writes give no output item.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): sets the length in use,
// always ready; write it only while no search is in flight.
// A write is stored when the engine takes it from the queue. A search with a
// nonzero length reads the store at position zero, then once per doubling
// probe and once per binary step, before its result goes to the output register.
// A two-entry queue sits in front of the engine, so input keeps being taken
// while the output stalls, until the queue fills and the engine holds its
// finished result. Reset empties the queue and output, sets length to 1024
// and leaves the store contents undefined until written.
// Depends on es_pkg, es_front, es_queue, es_engine.
module exponential_search #(
  parameter int unsigned DEPTH = es_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  es_pkg::in_item_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output es_pkg::out_item_t        out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [es_pkg::LEN_W-1:0] cfg_data
);

  logic [es_pkg::LEN_W-1:0] length;
  logic         push;
  logic         push_ready;
  es_pkg::cmd_t push_cmd;
  logic         pop_valid;
  logic         pop;
  es_pkg::cmd_t pop_cmd;

  // Length register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= es_pkg::LENGTH_RESET;
    end else if (cfg_valid) begin
      length <= cfg_data;
    end
  end

  es_front #(.DEPTH(DEPTH)) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .length     (length),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  es_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  es_engine #(.DEPTH(DEPTH)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop),
    .cmd       (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[dv/tb_exponential_search.sv]
`timescale 1ns / 100ps
// tb_exponential_search: self-checking testbench for the exponential search block.
// Holds a scoreboard class with its own search predictor, plus tasks that drive
// the item and length channels. Depends on es_pkg and exponential_search.
module tb_exponential_search;

  localparam int unsigned STORE_DEPTH  = es_pkg::DEPTH_DEFAULT;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 1000000;
  // Long lengths keep only this many leading entries filled; the last one sits
  // at a power-of-two position, so capping keys at it stops the probes there
  localparam int          SPAN_MAX     = 65;
  localparam logic signed [es_pkg::VALUE_W-1:0] KEY_MIN = 32'sh80000000;
  localparam logic signed [es_pkg::VALUE_W-1:0] KEY_MAX = 32'sh7fffffff;

  // Track the store and length, predict each search answer, check results
  class search_scoreboard;
    logic signed [es_pkg::VALUE_W-1:0] store_copy [STORE_DEPTH];
    logic [es_pkg::LEN_W-1:0]          length_copy = es_pkg::LENGTH_RESET;
    es_pkg::out_item_t                 expected_answers [$];
    int errors  = 0;
    int checked = 0;
    int hits    = 0;

    function void set_length(logic [es_pkg::LEN_W-1:0] len);
      length_copy = len;
    endfunction

    // Exponential probe, then binary search over the bracketed range
    function es_pkg::out_item_t locate_key(logic signed [es_pkg::VALUE_W-1:0] key);
      es_pkg::out_item_t ans;
      int unsigned n;
      int unsigned probe;
      int          lo, hi, mid;
      ans = '0;
      n = (length_copy > STORE_DEPTH) ? STORE_DEPTH : length_copy;
      if (n == 0) return ans;
      if (store_copy[0] == key) begin
        ans.found = 1'b1;
        return ans;
      end
      probe = 1;
      while (probe < n && store_copy[probe] < key) probe = probe * 2;
      lo = probe / 2;
      hi = (probe < n - 1) ? probe : n - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (key < store_copy[mid]) begin
          hi = mid - 1;
        end else if (store_copy[mid] < key) begin
          lo = mid + 1;
        end else begin
          ans.found    = 1'b1;
          ans.position = es_pkg::POS_W'(mid);
          return ans;
        end
      end
      return ans;
    endfunction

    function void note_item(es_pkg::in_item_t it);
      if (it.opcode == es_pkg::OP_WRITE) begin
        store_copy[it.address] = it.value;
      end else begin
        expected_answers.push_back(locate_key(it.value));
      end
    endfunction

    function void check_result(es_pkg::out_item_t got);
      es_pkg::out_item_t want;
      if (expected_answers.size() == 0) begin
        $error("result with no search waiting: found %0d position %0d",
               got.found, got.position);
        errors++;
        return;
      end
      want = expected_answers.pop_front();
      checked++;
      if (want.found) hits++;
      if (got.found !== want.found) begin
        $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position mismatch: expected %0d, actual %0d",
               want.position, got.position);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  es_pkg::in_item_t         in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  es_pkg::out_item_t        out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [es_pkg::LEN_W-1:0] cfg_data = '0;

  search_scoreboard sb = new;

  // Stimulus-side view of the store, used to pick keys and sorted writes
  logic signed [es_pkg::VALUE_W-1:0] plan_vals [STORE_DEPTH];
  bit                                plan_written [STORE_DEPTH];
  bit                                idle_on = 1'b1;
  int                                ready_hold = 0;
  int                                items_sent = 0;
  int                                cfg_writes = 0;

  exponential_search #(
    .DEPTH(STORE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result side at random while idling is on
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check every result item taken
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      sb.check_result(out_data);
    end
  end

  // Present one item, hold it until taken; valid stays high for a back-to-back item
  task automatic send_item(es_pkg::in_item_t it);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic write_elem(int addr, logic signed [es_pkg::VALUE_W-1:0] val);
    es_pkg::in_item_t it;
    it.opcode  = es_pkg::OP_WRITE;
    it.address = es_pkg::ADDR_W'(addr);
    it.value   = val;
    send_item(it);
    plan_vals[addr]    = val;
    plan_written[addr] = 1'b1;
  endtask

  task automatic search_key(logic signed [es_pkg::VALUE_W-1:0] key);
    es_pkg::in_item_t it;
    it.opcode  = es_pkg::OP_SEARCH;
    it.address = es_pkg::ADDR_W'($urandom);
    it.value   = key;
    send_item(it);
  endtask

  // Drop valid and hold off until every search answer has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_answers.size() != 0) @(posedge clk);
  endtask

  // Change the length only with the block idle
  task automatic set_length(logic [es_pkg::LEN_W-1:0] len);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.set_length(len);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Write positions 0..n-1 with ascending values: wide span, near-duplicates or small
  task automatic fill_sorted(int n);
    longint      v;
    int unsigned step_max;
    int          mode, a;
    mode = $urandom_range(0, 2);
    if (mode == 0) begin
      v = KEY_MIN;
      step_max = 32'hffffffff / n;
    end else if (mode == 1) begin
      v = longint'($signed($urandom));
      step_max = 2;
    end else begin
      v = longint'($urandom_range(0, 2000)) - 1000;
      step_max = 40;
    end
    for (a = 0; a < n; a++) begin
      if (v > KEY_MAX) v = KEY_MAX;
      if (mode == 0 && a == n - 1) v = KEY_MAX;
      write_elem(a, es_pkg::VALUE_W'(v));
      v = v + longint'($urandom_range(0, step_max));
    end
  endtask

  // One random item for an active length of n elements, first span of them filled
  task automatic random_item(int n, int span);
    int                                r, a;
    longint                            lo, hi;
    logic signed [es_pkg::VALUE_W-1:0] key;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      a = (span > 0) ? $urandom_range(0, span - 1) : 0;
      if (span == 0 || r >= 75) begin
        key = $urandom;
      end else if (r < 55) begin
        key = plan_vals[a];
      end else if (r < 70) begin
        key = plan_vals[a] + (($urandom_range(0, 1) == 0) ? -1 : 1);
      end else begin
        case ($urandom_range(0, 3))
          0:       key = KEY_MIN;
          1:       key = KEY_MAX;
          2:       key = 0;
          default: key = -1;
        endcase
      end
      // Cap the key so the probes stay inside the filled entries
      if (span < n && key > plan_vals[span - 1]) key = plan_vals[span - 1];
      search_key(key);
    end else if (r < 92 && span > 0) begin
      // Overwrite inside the filled range, keeping neighbors in order
      a  = $urandom_range(0, span - 1);
      lo = (a > 0) ? longint'(plan_vals[a - 1]) : longint'(KEY_MIN);
      hi = (a < span - 1) ? longint'(plan_vals[a + 1]) : longint'(KEY_MAX);
      if (hi < lo) hi = lo;
      write_elem(a, es_pkg::VALUE_W'(lo + longint'($urandom_range(0, 32'(hi - lo)))));
    end else if (r < 97 && n < STORE_DEPTH) begin
      // Write past the active range
      write_elem($urandom_range(n, STORE_DEPTH - 1), $urandom);
    end else begin
      // Noise: any position, any value, order may break
      write_elem($urandom_range(0, STORE_DEPTH - 1), $urandom);
    end
  endtask

  task automatic run_phase(int len, int count, bit refill, bit quiet);
    int n, span, a;
    bit hole;
    set_length(es_pkg::LEN_W'(len));
    idle_on = !quiet;
    n = (len > STORE_DEPTH) ? STORE_DEPTH : len;
    span = (n > SPAN_MAX) ? SPAN_MAX : n;
    hole = 1'b0;
    for (a = 0; a < span; a++) begin
      if (!plan_written[a]) hole = 1'b1;
    end
    if (refill || hole) fill_sorted(span);
    repeat (count) begin
      if ($urandom_range(0, 79) == 0) drain_results();
      random_item(n, span);
    end
  endtask

  // Directed: field extremes, duplicates, misses on both ends, empty and unsorted store
  task automatic run_directed();
    logic signed [es_pkg::VALUE_W-1:0] seed_vals [8];
    int a;
    seed_vals = '{KEY_MIN + 1, -5, -5, 0, 3, 100, 100, KEY_MAX - 1};
    set_length(es_pkg::LEN_W'(8));
    for (a = 0; a < 8; a++) write_elem(a, seed_vals[a]);
    search_key(KEY_MIN);
    search_key(KEY_MIN + 1);
    search_key(-5);
    search_key(0);
    search_key(3);
    search_key(4);
    search_key(100);
    search_key(KEY_MAX - 1);
    search_key(KEY_MAX);
    set_length(es_pkg::LEN_W'(0));
    search_key(0);
    set_length(es_pkg::LEN_W'(1));
    search_key(KEY_MIN + 1);
    search_key(7);
    set_length(es_pkg::LEN_W'(8));
    write_elem(3, -100);
    search_key(-100);
  endtask

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_phase(1,    30, 1'b1, 1'b0);
    run_phase(2,    30, 1'b1, 1'b0);
    run_phase(3,    20, 1'b0, 1'b1);
    run_phase(0,    20, 1'b0, 1'b0);
    run_phase(5,    40, 1'b1, 1'b0);
    run_phase(17,   60, 1'b1, 1'b0);
    run_phase(100,  70, 1'b1, 1'b0);
    run_phase(1024, 80, 1'b1, 1'b0);
    run_phase(2047, 50, 1'b0, 1'b0);
    run_phase(1025, 40, 1'b0, 1'b1);
    run_phase(1023, 50, 1'b0, 1'b0);
    run_phase(64,   60, 1'b1, 1'b1);
    run_phase(9,    40, 1'b1, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items across %0d length settings, lengths 0 through 2047.",
             items_sent, cfg_writes);
    $display("Checked %0d search answers, %0d of them hits, %0d mismatches.",
             sb.checked, sb.hits, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
